// File: hdl/tcse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone curve spline evaluator package
// Shared types and constants for the front end, the engine and the arithmetic
// unit.
// ----------------------------------------------------------------------------
package tcse_pkg;

  localparam int MAX_POINTS_DEF = 16;

  typedef enum logic [1:0] {
    OP_RESTORE = 2'd0,
    OP_INSERT  = 2'd1,
    OP_MOVE    = 2'd2,
    OP_EVAL    = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_MOVE = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] point_index;
    logic [7:0] point_x;
    logic [7:0] point_y;
    logic [7:0] sample_x;
  } req_t;

  typedef struct packed {
    logic [7:0] mapped_value;
    logic [3:0] placed_index;
    logic [1:0] status;
    logic [4:0] point_count;
  } rsp_t;

  // Classified command handed from the front end to the engine
  typedef struct packed {
    op_t        op;
    logic [3:0] point_index;
    logic [7:0] point_x;
    logic [7:0] point_y;
    logic [7:0] sample_x;
  } cmd_t;

  // Handshake between engine and arithmetic unit
  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } arith_rsp_t;

endpackage

// File: hdl/tcse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts transactions, decodes the opcode and holds up to two commands for
// the engine.
// ----------------------------------------------------------------------------
module tcse_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  tcse_pkg::req_t request,
  output logic           cmd_valid,
  output tcse_pkg::cmd_t cmd,
  input  logic           cmd_take
);
  import tcse_pkg::*;

  cmd_t       slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       wr_en;
  logic       rd_en;
  cmd_t       decoded;

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rp];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_take && cmd_valid;

  always_comb begin
    decoded.op          = op_t'(request.opcode);
    decoded.point_index = request.point_index;
    decoded.point_x     = request.point_x;
    decoded.point_y     = request.point_y;
    decoded.sample_x    = request.sample_x;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wp] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr_en) begin
        wp <= ~wp;
      end
      if (rd_en) begin
        rp <= ~rp;
      end
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hdl/tcse_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spline arithmetic unit
// Forms the Catmull-Rom numerator with one shared multiplier, then rounds,
// clamps and divides by the denominator one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcse_arith (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [7:0]           p0,
  input  logic [7:0]           p1,
  input  logic [7:0]           p2,
  input  logic [7:0]           p3,
  input  logic [7:0]           xk,
  input  logic [7:0]           xi2,
  input  logic [7:0]           sx,
  output tcse_pkg::arith_rsp_t rsp
);
  import tcse_pkg::*;

  typedef enum logic [13:0] {
    A_IDLE = 14'b1 << 0,
    A_W2   = 14'b1 << 1,
    A_W3   = 14'b1 << 2,
    A_D2   = 14'b1 << 3,
    A_D3   = 14'b1 << 4,
    A_DW2  = 14'b1 << 5,
    A_D2W  = 14'b1 << 6,
    A_T1   = 14'b1 << 7,
    A_T2   = 14'b1 << 8,
    A_T3   = 14'b1 << 9,
    A_T4   = 14'b1 << 10,
    A_SUM  = 14'b1 << 11,
    A_CHK  = 14'b1 << 12,
    A_DIV  = 14'b1 << 13
  } astate_t;

  astate_t             state;
  logic [7:0]          w;
  logic [7:0]          d;
  logic [7:0]          p1r;
  logic signed [11:0]  ca;
  logic signed [11:0]  cb;
  logic signed [11:0]  cc;
  logic [15:0]         w2;
  logic [23:0]         w3;
  logic [15:0]         d2;
  logic [23:0]         d3;
  logic [23:0]         dw2;
  logic [23:0]         d2w;
  logic signed [38:0]  term;
  logic signed [39:0]  acc;
  logic [32:0]         rem;
  logic [32:0]         dv;
  logic [7:0]          quo;
  logic [2:0]          cnt;

  logic signed [25:0]  ma;
  logic signed [12:0]  mb;
  logic signed [38:0]  prod;
  logic signed [8:0]   w9;
  logic signed [8:0]   d9;
  logic signed [11:0]  e0;
  logic signed [11:0]  e1;
  logic signed [11:0]  e2;
  logic signed [11:0]  e3;
  logic signed [39:0]  lim;
  logic [7:0]          quo_next;
  logic                finish;

  assign e0 = signed'({4'b0, p0});
  assign e1 = signed'({4'b0, p1});
  assign e2 = signed'({4'b0, p2});
  assign e3 = signed'({4'b0, p3});
  assign w9 = signed'({1'b0, xi2}) - signed'({1'b0, xk});
  assign d9 = signed'({1'b0, sx}) - signed'({1'b0, xk});
  // 255 * den = 510 * w^3
  assign lim = signed'({7'b0, w3, 9'b0}) - signed'({15'b0, w3, 1'b0});
  assign quo_next = {quo[6:0], (rem >= dv)};
  // result is ready on a clamp or on the last quotient bit
  assign finish = ((state == A_CHK) && ((acc <= 40'sd0) || (acc >= lim))) ||
                  ((state == A_DIV) && (cnt == 3'd0));

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      A_W2:    begin ma = signed'({18'b0, w});   mb = signed'({5'b0, w}); end
      A_W3:    begin ma = signed'({10'b0, w2});  mb = signed'({5'b0, w}); end
      A_D2:    begin ma = signed'({18'b0, d});   mb = signed'({5'b0, d}); end
      A_D3:    begin ma = signed'({10'b0, d2});  mb = signed'({5'b0, d}); end
      A_DW2:   begin ma = signed'({10'b0, w2});  mb = signed'({5'b0, d}); end
      A_D2W:   begin ma = signed'({10'b0, d2});  mb = signed'({5'b0, w}); end
      A_T1:    begin ma = signed'({2'b0, w3});   mb = signed'({5'b0, p1r}); end
      A_T2:    begin ma = signed'({2'b0, dw2});  mb = 13'(ca); end
      A_T3:    begin ma = signed'({2'b0, d2w});  mb = 13'(cb); end
      A_T4:    begin ma = signed'({2'b0, d3});   mb = 13'(cc); end
      default: begin ma = '0;                    mb = '0; end
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= finish;
      case (state)
        A_IDLE: begin
          if (start) begin
            // degenerate segment gives t = 0, overshoot gives t = 1
            if (w9 <= 9'sd0 || d9 <= 9'sd0) begin
              w <= 8'd1;
              d <= 8'd0;
            end else if (d9 >= w9) begin
              w <= 8'd1;
              d <= 8'd1;
            end else begin
              w <= w9[7:0];
              d <= d9[7:0];
            end
            p1r   <= p1;
            ca    <= e2 - e0;
            cb    <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
            cc    <= e1 + (e1 <<< 1) - e2 - (e2 <<< 1) + e3 - e0;
            state <= A_W2;
          end
        end
        A_W2:  begin w2  <= prod[15:0]; state <= A_W3;  end
        A_W3:  begin w3  <= prod[23:0]; state <= A_D2;  end
        A_D2:  begin d2  <= prod[15:0]; state <= A_D3;  end
        A_D3:  begin d3  <= prod[23:0]; state <= A_DW2; end
        A_DW2: begin dw2 <= prod[23:0]; state <= A_D2W; end
        A_D2W: begin d2w <= prod[23:0]; state <= A_T1;  end
        A_T1:  begin term <= prod; state <= A_T2; end
        A_T2: begin
          acc   <= 40'(term) <<< 1;
          term  <= prod;
          state <= A_T3;
        end
        A_T3: begin
          acc   <= acc + 40'(term);
          term  <= prod;
          state <= A_T4;
        end
        A_T4: begin
          acc   <= acc + 40'(term);
          term  <= prod;
          state <= A_SUM;
        end
        A_SUM: begin
          acc   <= acc + 40'(term);
          state <= A_CHK;
        end
        A_CHK: begin
          if (acc <= 40'sd0) begin
            rsp.value <= 8'd0;
            state     <= A_IDLE;
          end else if (acc >= lim) begin
            rsp.value <= 8'd255;
            state     <= A_IDLE;
          end else begin
            // round half up: (num + w^3) / (2 w^3)
            rem   <= acc[32:0] + {9'b0, w3};
            dv    <= {1'b0, w3, 8'b0};
            quo   <= 8'd0;
            cnt   <= 3'd7;
            state <= A_DIV;
          end
        end
        A_DIV: begin
          if (rem >= dv) begin
            rem <= rem - dv;
          end
          quo <= quo_next;
          dv  <= dv >> 1;
          cnt <= cnt - 3'd1;
          if (cnt == 3'd0) begin
            rsp.value <= quo_next;
            state     <= A_IDLE;
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/tcse_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command engine
// Owns the control point store, runs restore, insert, move and segment search, and
// holds the finished result until it is taken.
// ----------------------------------------------------------------------------
module tcse_engine #(
  parameter int MAX_POINTS = tcse_pkg::MAX_POINTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  tcse_pkg::cmd_t cmd,
  output logic           cmd_take,
  output logic           res_valid,
  output tcse_pkg::rsp_t res,
  input  logic           res_pop
);
  import tcse_pkg::*;

  localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [16:0] {
    E_INIT0 = 17'b1 << 0,
    E_INIT1 = 17'b1 << 1,
    E_IDLE  = 17'b1 << 2,
    E_IRD   = 17'b1 << 3,
    E_ICMP  = 17'b1 << 4,
    E_SRD   = 17'b1 << 5,
    E_SWR   = 17'b1 << 6,
    E_IWR   = 17'b1 << 7,
    E_MRD1  = 17'b1 << 8,
    E_MRD2  = 17'b1 << 9,
    E_MWR   = 17'b1 << 10,
    E_ERD   = 17'b1 << 11,
    E_ECMP  = 17'b1 << 12,
    E_GATH  = 17'b1 << 13,
    E_CALC  = 17'b1 << 14,
    E_DONE  = 17'b1 << 15,
    E_WAIT  = 17'b1 << 16
  } estate_t;

  logic [7:0] x_mem [MAX_POINTS];
  logic [7:0] y_mem [MAX_POINTS];

  estate_t           state;
  logic [CW-1:0]     count;
  cmd_t              cur;
  logic              respond;
  logic [AW-1:0]     pos;
  logic [AW-1:0]     j;
  logic [AW-1:0]     k;
  logic [2:0]        g;
  logic signed [9:0] lo;
  logic [7:0]        mx;
  logic [7:0]        p0;
  logic [7:0]        p1;
  logic [7:0]        p2;
  logic [7:0]        xk;
  logic [7:0]        xi2;
  logic [7:0]        rd_x;
  logic [7:0]        rd_y;
  logic [7:0]        r_mapped;
  logic [3:0]        r_placed;
  logic [1:0]        r_status;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [7:0]        wx;
  logic [7:0]        wy;
  logic [AW-1:0]     raddr;
  logic              a_start;
  arith_rsp_t        a_rsp;

  logic [CW:0]       kk;
  logic [CW:0]       nn;
  logic [AW-1:0]     i0;
  logic [AW-1:0]     i2;
  logic [AW-1:0]     i3;
  logic signed [9:0] hi;
  logic signed [9:0] bmin;
  logic signed [9:0] bmax;
  logic signed [9:0] pxs;
  logic [7:0]        clamped;

  assign cmd_take = (state == E_IDLE) && cmd_valid;

  // neighbour indices clamped to the list ends
  assign kk = (CW + 1)'(k);
  assign nn = (CW + 1)'(count);
  assign i0 = (k != '0) ? k - AW'(1) : '0;
  assign i2 = (kk + 1 < nn - 1) ? AW'(kk + 1) : AW'(nn - 1);
  assign i3 = (kk + 2 < nn - 1) ? AW'(kk + 2) : AW'(nn - 1);

  // move bounds: order the neighbour limits, then clamp
  assign hi      = signed'({2'b0, rd_x}) - 10'sd1;
  assign bmin    = (lo > hi) ? hi : lo;
  assign bmax    = (lo > hi) ? lo : hi;
  assign pxs     = signed'({2'b0, cur.point_x});
  assign clamped = (pxs < bmin) ? bmin[7:0] : ((pxs > bmax) ? bmax[7:0] : cur.point_x);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wx    = '0;
    wy    = '0;
    raddr = '0;
    case (state)
      E_INIT0: begin we = 1'b1; waddr = '0; wx = 8'd0; wy = 8'd0; end
      E_INIT1: begin we = 1'b1; waddr = AW'(1); wx = 8'd255; wy = 8'd255; end
      E_IRD:   raddr = pos;
      E_SRD:   raddr = j - AW'(1);
      E_SWR:   begin we = 1'b1; waddr = j; wx = rd_x; wy = rd_y; end
      E_IWR:   begin we = 1'b1; waddr = pos; wx = cur.point_x; wy = cur.point_y; end
      E_IDLE:  raddr = AW'(cmd.point_index) - AW'(1);
      E_MRD1:  raddr = AW'(cur.point_index) + AW'(1);
      E_MWR: begin
        we    = 1'b1;
        waddr = AW'(cur.point_index);
        wx    = mx;
        wy    = cur.point_y;
      end
      E_ERD:   raddr = k + AW'(1);
      E_GATH: begin
        case (g)
          3'd0:    raddr = i0;
          3'd1:    raddr = k;
          3'd2:    raddr = i2;
          3'd3:    raddr = i3;
          default: raddr = '0;
        endcase
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      x_mem[waddr] <= wx;
      y_mem[waddr] <= wy;
    end
    rd_x <= x_mem[raddr];
    rd_y <= y_mem[raddr];
  end

  assign a_start = (state == E_GATH) && (g == 3'd4);

  tcse_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (a_start),
    .p0    (p0),
    .p1    (p1),
    .p2    (p2),
    .p3    (rd_y),
    .xk    (xk),
    .xi2   (xi2),
    .sx    (cur.sample_x),
    .rsp   (a_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_INIT0;
      respond   <= 1'b0;
      count     <= CW'(2);
      res_valid <= 1'b0;
    end else begin
      // a pop while the next result is loaded is covered in E_WAIT
      if (res_pop && res_valid && (state != E_WAIT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        E_INIT0: state <= E_INIT1;
        E_INIT1: begin
          count <= CW'(2);
          state <= respond ? E_DONE : E_IDLE;
        end
        E_IDLE: begin
          if (cmd_valid) begin
            cur      <= cmd;
            r_mapped <= 8'd0;
            r_placed <= 4'd0;
            pos      <= '0;
            k        <= '0;
            g        <= 3'd0;
            case (cmd.op)
              OP_RESTORE: begin
                r_status <= ST_OK;
                respond  <= 1'b1;
                state    <= E_INIT0;
              end
              OP_INSERT: begin
                if (count >= CW'(MAX_POINTS)) begin
                  r_status <= ST_FULL;
                  state    <= E_DONE;
                end else begin
                  r_status <= ST_OK;
                  state    <= E_IRD;
                end
              end
              OP_MOVE: begin
                if (8'(cmd.point_index) >= 8'(count)) begin
                  r_status <= ST_BAD_MOVE;
                  state    <= E_DONE;
                end else begin
                  r_status <= ST_OK;
                  if (cmd.point_index == 4'd0) begin
                    mx    <= 8'd0;
                    state <= E_MWR;
                  end else if (8'(cmd.point_index) == 8'(count) - 8'd1) begin
                    mx    <= 8'd255;
                    state <= E_MWR;
                  end else begin
                    state <= E_MRD1;
                  end
                end
              end
              OP_EVAL: begin
                r_status <= ST_OK;
                state    <= E_ERD;
              end
              default: state <= E_IDLE;
            endcase
          end
        end
        E_IRD: begin
          if (CW'(pos) == count) begin
            j     <= AW'(count);
            state <= E_SRD;
          end else begin
            state <= E_ICMP;
          end
        end
        E_ICMP: begin
          if (rd_x < cur.point_x) begin
            pos   <= pos + AW'(1);
            state <= E_IRD;
          end else begin
            j     <= AW'(count);
            state <= E_SRD;
          end
        end
        E_SRD: state <= (j == pos) ? E_IWR : E_SWR;
        E_SWR: begin
          j     <= j - AW'(1);
          state <= E_SRD;
        end
        E_IWR: begin
          count    <= count + CW'(1);
          r_placed <= 4'(pos);
          state    <= E_DONE;
        end
        E_MRD1: begin
          lo    <= signed'({2'b0, rd_x}) + 10'sd1;
          state <= E_MRD2;
        end
        E_MRD2: begin
          mx    <= clamped;
          state <= E_MWR;
        end
        E_MWR: begin
          r_placed <= cur.point_index;
          state    <= E_DONE;
        end
        E_ERD: begin
          if (kk + 2 >= nn) begin
            state <= E_GATH;
          end else begin
            state <= E_ECMP;
          end
        end
        E_ECMP: begin
          if (rd_x < cur.sample_x) begin
            k     <= k + AW'(1);
            state <= E_ERD;
          end else begin
            state <= E_GATH;
          end
        end
        E_GATH: begin
          // read data arrives in the cycle after its address
          case (g)
            3'd1:    p0 <= rd_y;
            3'd2:    begin p1 <= rd_y; xk  <= rd_x; end
            3'd3:    begin p2 <= rd_y; xi2 <= rd_x; end
            default: p0 <= p0;
          endcase
          g <= g + 3'd1;
          if (g == 3'd4) begin
            state <= E_CALC;
          end
        end
        E_CALC: begin
          if (a_rsp.done) begin
            r_mapped <= a_rsp.value;
            state    <= E_DONE;
          end
        end
        E_DONE: state <= E_WAIT;
        E_WAIT: begin
          if (!res_valid || res_pop) begin
            res_valid        <= 1'b1;
            res.mapped_value <= r_mapped;
            res.placed_index <= r_placed;
            res.status       <= r_status;
            res.point_count  <= 5'(count);
            state            <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/tone_curve_spline_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone curve spline evaluator
// Sorted list of control points with insert, move, restore and Catmull-Rom
// evaluation of 8-bit sample levels.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue: drive request and push; a transaction is taken
//   on a clock edge with push high and full low. Response side is a queue:
//   the oldest response sits on response while empty is low; pop takes it.
//   Every request gives exactly one response, in order.
//   Work per request:
//     restore  rewrites the two end points
//     insert   reads x upward to find the position, shifts the points above
//              it up one slot and writes the new point; a full list is refused
//     move     clamps x between its neighbours inside the list, pins an end
//              point to x = 0 or 255, and refuses an index out of range
//     evaluate reads x per segment in the search, then 10 multiplier steps
//              and 8 divider steps (8 fewer when the value clamps to 0 or 255)
//   One item is worked at a time; the single store port and the serial
//   multiplier and divider set the pace. Two further requests queue at
//   the front while the engine works.
//   Reset (rst, synchronous) restores the identity curve: the store writes
//   its two end points before the first request is taken.
//   A stalled receiver holds one response; the engine then waits with the
//   next result and the request queue fills, raising full.
// ----------------------------------------------------------------------------
module tone_curve_spline_evaluator_unit #(
  parameter int MAX_POINTS = tcse_pkg::MAX_POINTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  tcse_pkg::req_t request,
  output logic           empty,
  input  logic           pop,
  output tcse_pkg::rsp_t response
);
  import tcse_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic res_valid;

  // decode and buffer incoming transactions
  tcse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // execute commands against the point store; hold the result for pop
  tcse_engine #(
    .MAX_POINTS (MAX_POINTS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_valid (res_valid),
    .res       (response),
    .res_pop   (pop)
  );

  assign empty = !res_valid;

endmodule
